@@ sv/triangle_normal_and_area_top_assert.svh @@
// Assertion macros for the triangle normal and area block.
// Included by the checker module; no other dependencies.
`ifndef TRIANGLE_NORMAL_AND_AREA_TOP_ASSERT_SVH
`define TRIANGLE_NORMAL_AND_AREA_TOP_ASSERT_SVH

// Same-cycle implication.
`define TNA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("triangle normal and area check failed");

// Next-cycle implication.
`define TNA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("triangle normal and area check failed");

`endif

@@ sv/tna_pkg.sv @@
// Package for the triangle normal and area block: widths, limits, item types.
// No dependencies; used by every module of the block.
package tna_pkg;

  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 15;
  localparam int FIELD_W          = 16;
  localparam int OUT_W            = 16;
  localparam int AREA_W           = 33;

  // Edge vectors, products, cross product and its squared length
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int NW    = PW + 1;
  localparam int MW    = NW - 1;
  localparam int M2W   = 2 * MW;
  localparam int SQW   = M2W + 2;

  // Area root: radicand 4*|n|^2
  localparam int RAD_W   = SQW + 2;
  localparam int AREA_RB = RAD_W / 2;

  // Normal: quotient m^2*2^(2F+2)/|n|^2, then its root
  localparam int QB  = 2 * NORMAL_FRAC_BITS + 3;
  localparam int DRW = QB + 1;
  localparam int NRB = DRW / 2;
  localparam int NST = QB + NRB;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;
  localparam logic [NRB-1:0] LIM_POS =
    NRB'((NORMAL_FRAC_BITS >= 15) ? 32767 : (2 ** NORMAL_FRAC_BITS) - 1);
  localparam logic [NRB-1:0] LIM_NEG =
    NRB'((NORMAL_FRAC_BITS >= 15) ? 32768 : (2 ** NORMAL_FRAC_BITS));

  typedef struct packed {
    logic [FIELD_W-1:0] a_x;
    logic [FIELD_W-1:0] a_y;
    logic [FIELD_W-1:0] a_z;
    logic [FIELD_W-1:0] b_x;
    logic [FIELD_W-1:0] b_y;
    logic [FIELD_W-1:0] b_z;
    logic [FIELD_W-1:0] c_x;
    logic [FIELD_W-1:0] c_y;
    logic [FIELD_W-1:0] c_z;
  } vtx_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] unit_nx;
    logic signed [OUT_W-1:0] unit_ny;
    logic signed [OUT_W-1:0] unit_nz;
    logic [AREA_W-1:0]       twice_area;
    logic                    degenerate;
  } res_t;

  // One stage of the divide / square-root pipeline
  typedef struct packed {
    logic                      degen;
    logic [2:0]                neg;
    logic [SQW-1:0]            sq;
    logic [2:0][SQW-1:0]       rem;
    logic [2:0]                lsb;
    logic [2:0][DRW-1:0]       quo;
    logic [2:0][NRB:0]         nrem;
    logic [2:0][NRB-1:0]       nroot;
    logic [RAD_W-1:0]          arad;
    logic [AREA_RB:0]          arem;
    logic [AREA_RB-1:0]        aroot;
  } it_t;

endpackage

@@ sv/tna_iter.sv @@
// Divide and square-root pipeline: one restoring step per register stage.
// Depends on tna_pkg.
module tna_iter
  import tna_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic ce,
  input  logic in_vld,
  input  it_t  in_it,
  output logic out_vld,
  output it_t  out_it
);

  it_t  pipe [0:NST];
  logic vp   [0:NST];

  // Entry register
  always_ff @(posedge clk) begin
    if (ce) pipe[0] <= in_it;
  end

  always_ff @(posedge clk) begin
    if (rst) vp[0] <= 1'b0;
    else if (ce) vp[0] <= in_vld;
  end

  genvar k;
  for (k = 0; k < NST; k++) begin : g_stage
    it_t nxt;

    // First QB stages divide, the rest take the root of the quotient.
    // The area root runs in parallel over the first AREA_RB stages.
    always_comb begin
      logic [SQW:0]       dt;
      logic               qbit;
      logic [NRB+2:0]     nt;
      logic [NRB+2:0]     ntr;
      logic [AREA_RB+2:0] at;
      logic [AREA_RB+2:0] atr;
      nxt  = pipe[k];
      dt   = '0;
      qbit = 1'b0;
      nt   = '0;
      ntr  = '0;
      at   = '0;
      atr  = '0;
      for (int i = 0; i < 3; i++) begin
        if (k < QB) begin
          dt = {pipe[k].rem[i], (k == 0) ? pipe[k].lsb[i] : 1'b0};
          qbit = (dt >= {1'b0, pipe[k].sq});
          if (qbit) nxt.rem[i] = SQW'(dt - {1'b0, pipe[k].sq});
          else nxt.rem[i] = dt[SQW-1:0];
          nxt.quo[i] = {pipe[k].quo[i][DRW-2:0], qbit};
        end else begin
          nt  = {pipe[k].nrem[i], pipe[k].quo[i][DRW-1 -: 2]};
          ntr = {1'b0, pipe[k].nroot[i], 2'b01};
          if (nt >= ntr) begin
            nxt.nrem[i]  = (NRB+1)'(nt - ntr);
            nxt.nroot[i] = {pipe[k].nroot[i][NRB-2:0], 1'b1};
          end else begin
            nxt.nrem[i]  = nt[NRB:0];
            nxt.nroot[i] = {pipe[k].nroot[i][NRB-2:0], 1'b0};
          end
          nxt.quo[i] = {pipe[k].quo[i][DRW-3:0], 2'b00};
        end
      end
      if (k < AREA_RB) begin
        at  = {pipe[k].arem, pipe[k].arad[RAD_W-1 -: 2]};
        atr = {1'b0, pipe[k].aroot, 2'b01};
        if (at >= atr) begin
          nxt.arem  = (AREA_RB+1)'(at - atr);
          nxt.aroot = {pipe[k].aroot[AREA_RB-2:0], 1'b1};
        end else begin
          nxt.arem  = at[AREA_RB:0];
          nxt.aroot = {pipe[k].aroot[AREA_RB-2:0], 1'b0};
        end
        nxt.arad = {pipe[k].arad[RAD_W-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (ce) pipe[k+1] <= nxt;
    end

    always_ff @(posedge clk) begin
      if (rst) vp[k+1] <= 1'b0;
      else if (ce) vp[k+1] <= vp[k];
    end
  end

  assign out_vld = vp[NST];
  assign out_it  = pipe[NST];

endmodule

@@ sv/triangle_normal_and_area_top.sv @@
// Triangle unit normal and twice-area: top level with the front pipeline
// and output formatting. Depends on tna_pkg and tna_iter.
//
// Usage: one triangle item enters on vtx/vtx_valid, one result item leaves
// on res/res_valid for every triangle, in order.
// Throughput: one item per cycle whenever the result side is not stalled.
// Stages: four arithmetic stages
// (edges, products, cross product, squares), then an entry register and
// 50 stages of restoring divide and square root steps (one bit per stage),
// then the output register.
// All stages advance together; while res_valid is high and res_stall is
// high the whole pipeline holds and vtx_stall is raised, so nothing is lost
// or repeated. Empty stages are filled as items flow.
// Degenerate triangles give a zero normal, zero area and degenerate = 1.
// Reset (synchronous, active high) empties the pipeline; no result is
// pending afterward and no clearing pass is needed.
module triangle_normal_and_area_top
  import tna_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic vtx_valid,
  output logic vtx_stall,
  input  vtx_t vtx,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic ce;
  assign ce        = !res_valid || !res_stall;
  assign vtx_stall = !ce;

  // Vertex coordinates, low COORD_BITS used
  logic [COORD_BITS-1:0] pa [3];
  logic [COORD_BITS-1:0] pb [3];
  logic [COORD_BITS-1:0] pc [3];
  assign pa[0] = vtx.a_x[COORD_BITS-1:0];
  assign pa[1] = vtx.a_y[COORD_BITS-1:0];
  assign pa[2] = vtx.a_z[COORD_BITS-1:0];
  assign pb[0] = vtx.b_x[COORD_BITS-1:0];
  assign pb[1] = vtx.b_y[COORD_BITS-1:0];
  assign pb[2] = vtx.b_z[COORD_BITS-1:0];
  assign pc[0] = vtx.c_x[COORD_BITS-1:0];
  assign pc[1] = vtx.c_y[COORD_BITS-1:0];
  assign pc[2] = vtx.c_z[COORD_BITS-1:0];

  logic v1, v2, v3, v4;
  logic signed [DW-1:0] s1_u [3];
  logic signed [DW-1:0] s1_v [3];
  logic signed [PW-1:0] s2_p [6];
  logic [MW-1:0]        s3_mag [3];
  logic [2:0]           s3_neg;
  logic [M2W-1:0]       s4_m2 [3];
  logic [2:0]           s4_neg;

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (ce) begin
      v1 <= vtx_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage 1: edge vectors
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s1_u[i] <= $signed({1'b0, pb[i]}) - $signed({1'b0, pa[i]});
        s1_v[i] <= $signed({1'b0, pc[i]}) - $signed({1'b0, pa[i]});
      end
    end
  end

  // Stage 2: cross product terms
  always_ff @(posedge clk) begin
    if (ce) begin
      s2_p[0] <= s1_u[1] * s1_v[2];
      s2_p[1] <= s1_u[2] * s1_v[1];
      s2_p[2] <= s1_u[2] * s1_v[0];
      s2_p[3] <= s1_u[0] * s1_v[2];
      s2_p[4] <= s1_u[0] * s1_v[1];
      s2_p[5] <= s1_u[1] * s1_v[0];
    end
  end

  // Stage 3: cross product, sign and magnitude
  logic signed [NW-1:0] n_c [3];
  logic [NW-1:0]        nabs [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_c[i]  = NW'(s2_p[2*i]) - NW'(s2_p[2*i+1]);
      nabs[i] = n_c[i][NW-1] ? NW'(-n_c[i]) : NW'(n_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        s3_mag[i] <= nabs[i][MW-1:0];
        s3_neg[i] <= n_c[i][NW-1];
      end
    end
  end

  // Stage 4: squared components
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) s4_m2[i] <= s3_mag[i] * s3_mag[i];
      s4_neg <= s3_neg;
    end
  end

  // Squared length and initial divide / root state
  it_t it_in;
  logic [SQW-1:0] sq_c;
  always_comb begin
    sq_c = SQW'(s4_m2[0]) + SQW'(s4_m2[1]) + SQW'(s4_m2[2]);
    it_in       = '0;
    it_in.degen = (sq_c == '0);
    it_in.neg   = s4_neg;
    it_in.sq    = sq_c;
    for (int i = 0; i < 3; i++) begin
      it_in.rem[i] = SQW'(s4_m2[i] >> 1);
      it_in.lsb[i] = s4_m2[i][0];
    end
    it_in.arad = {sq_c, 2'b00};
  end

  logic it_vld;
  it_t  it_out;

  tna_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .ce      (ce),
    .in_vld  (v4),
    .in_it   (it_in),
    .out_vld (it_vld),
    .out_it  (it_out)
  );

  // Rounding, saturation and degenerate override
  res_t              fmt;
  logic [NRB:0]      rs [3];
  logic [NRB-1:0]    rr [3];
  logic [OUT_W-1:0]  mg [3];
  logic [OUT_W-1:0]  comp [3];
  logic [AREA_RB:0]  ars;
  logic [AREA_RB-1:0] ar;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = {1'b0, it_out.nroot[i]} + (NRB+1)'(1);
      rr[i] = rs[i][NRB:1];
      if (it_out.neg[i]) begin
        if (rr[i] > LIM_NEG) rr[i] = LIM_NEG;
      end else begin
        if (rr[i] > LIM_POS) rr[i] = LIM_POS;
      end
      mg[i]   = OUT_W'(rr[i]);
      comp[i] = it_out.neg[i] ? (~mg[i] + OUT_W'(1)) : mg[i];
      if (it_out.degen) comp[i] = '0;
    end
    ars = {1'b0, it_out.aroot} + (AREA_RB+1)'(1);
    ar  = ars[AREA_RB:1];
    if (ar > AREA_RB'(AREA_MAX)) ar = AREA_RB'(AREA_MAX);
    fmt.unit_nx    = $signed(comp[0]);
    fmt.unit_ny    = $signed(comp[1]);
    fmt.unit_nz    = $signed(comp[2]);
    fmt.twice_area = it_out.degen ? '0 : AREA_W'(ar);
    fmt.degenerate = it_out.degen;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (ce) res_valid <= it_vld;
  end

  always_ff @(posedge clk) begin
    if (ce) res <= fmt;
  end

endmodule

@@ sv/tna_check.sv @@
// Port-level checker for the triangle normal and area block, with its bind.
// Depends on tna_pkg and the assertion macro header.
`include "triangle_normal_and_area_top_assert.svh"

module tna_check
  import tna_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic vtx_stall,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // Reset empties the output
  `TNA_ASSERT_NXT(a_rst_empty, clk, 1'b0, rst, !res_valid)

  // A stalled result holds
  `TNA_ASSERT_NXT(a_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))

  // Input is held back exactly when a result is stuck
  `TNA_ASSERT_IMP(a_back, clk, rst, 1'b1, vtx_stall == (res_valid && res_stall))

  // Degenerate items carry a zero normal and zero area
  `TNA_ASSERT_IMP(a_degen, clk, rst, res_valid && res.degenerate, (res.unit_nx == '0) && (res.unit_ny == '0) && (res.unit_nz == '0) && (res.twice_area == '0))

  // Any real triangle has nonzero area
  `TNA_ASSERT_IMP(a_area, clk, rst, res_valid && !res.degenerate, res.twice_area != '0)

endmodule

bind triangle_normal_and_area_top tna_check u_tna_check (
  .clk       (clk),
  .rst       (rst),
  .vtx_stall (vtx_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

@@ test/tna_checker.sv @@
// Scoreboard for the triangle normal and area block: watches both channels,
// predicts each result from the accepted triangle and compares field by field.
// Depends on tna_pkg.
module tna_checker
  import tna_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   vtx_valid,
  input  logic   vtx_stall,
  input  vtx_t   vtx,
  input  logic   res_valid,
  input  logic   res_stall,
  input  res_t   res,
  output int     errors,
  output int     pending,
  output int     degen_seen
);

  res_t expected_q[$];

  // Largest r below 2^(top+1) with (2r-1)^2 * mult <= target
  function automatic logic [63:0] round_root(logic [127:0] mult, logic [127:0] target,
                                             int top);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] o;
    r = '0;
    for (int b = top; b >= 0; b--) begin
      t = r | (64'd1 << b);
      o = 128'(2 * t - 1);
      if (o * o * mult <= target) r = t;
    end
    return r;
  endfunction

  // Unit normal and twice-area of one triangle
  function automatic res_t triangle_normal(vtx_t t);
    res_t         r;
    longint       u[3];
    longint       v[3];
    longint       n[3];
    logic [127:0] m2[3];
    logic [127:0] sq;
    logic [63:0]  area;
    logic [63:0]  q;
    longint       cm;
    cm = (longint'(1) << COORD_BITS) - 1;
    u[0] = (longint'(t.b_x) & cm) - (longint'(t.a_x) & cm);
    u[1] = (longint'(t.b_y) & cm) - (longint'(t.a_y) & cm);
    u[2] = (longint'(t.b_z) & cm) - (longint'(t.a_z) & cm);
    v[0] = (longint'(t.c_x) & cm) - (longint'(t.a_x) & cm);
    v[1] = (longint'(t.c_y) & cm) - (longint'(t.a_y) & cm);
    v[2] = (longint'(t.c_z) & cm) - (longint'(t.a_z) & cm);
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      m2[i] = 128'(n[i] < 0 ? -n[i] : n[i]);
      m2[i] = m2[i] * m2[i];
      sq += m2[i];
    end
    r = '0;
    if (sq == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    area = round_root(128'd1, sq << 2, 53);
    r.twice_area = (area > 64'(AREA_MAX)) ? AREA_MAX : area[AREA_W-1:0];
    for (int i = 0; i < 3; i++) begin
      q = round_root(sq, m2[i] << (2 * NORMAL_FRAC_BITS + 2), NORMAL_FRAC_BITS + 1);
      if (n[i] >= 0) begin
        if (q > (64'd1 << NORMAL_FRAC_BITS) - 1) q = (64'd1 << NORMAL_FRAC_BITS) - 1;
        if (q > 64'd32767) q = 64'd32767;
      end else begin
        if (q > (64'd1 << NORMAL_FRAC_BITS)) q = 64'd1 << NORMAL_FRAC_BITS;
        if (q > 64'd32768) q = 64'd32768;
        q = -q;
      end
      case (i)
        0: r.unit_nx = q[15:0];
        1: r.unit_ny = q[15:0];
        default: r.unit_nz = q[15:0];
      endcase
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  // Predict on accepted triangles, compare accepted results
  always @(posedge clk) begin
    res_t e;
    int   nerr;
    nerr = 0;
    if (rst) begin
      errors     <= 0;
      degen_seen <= 0;
    end else begin
      if (vtx_valid && !vtx_stall) expected_q.push_back(triangle_normal(vtx));
      if (res_valid && !res_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          nerr++;
        end else begin
          e = expected_q.pop_front();
          if (res.degenerate) degen_seen <= degen_seen + 1;
          if (res.unit_nx !== e.unit_nx) begin
            $error("unit_nx expected %0d got %0d", e.unit_nx, res.unit_nx);
            nerr++;
          end
          if (res.unit_ny !== e.unit_ny) begin
            $error("unit_ny expected %0d got %0d", e.unit_ny, res.unit_ny);
            nerr++;
          end
          if (res.unit_nz !== e.unit_nz) begin
            $error("unit_nz expected %0d got %0d", e.unit_nz, res.unit_nz);
            nerr++;
          end
          if (res.twice_area !== e.twice_area) begin
            $error("twice_area expected %0d got %0d", e.twice_area, res.twice_area);
            nerr++;
          end
          if (res.degenerate !== e.degenerate) begin
            $error("degenerate expected %0d got %0d", e.degenerate, res.degenerate);
            nerr++;
          end
        end
      end
      if (nerr != 0) errors <= errors + nerr;
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top for triangle_normal_and_area_top: clock, reset, triangle
// stimulus with bursty sender and stalling receiver. Depends on tna_pkg, tna_checker.
module tb;
  import tna_pkg::*;

  logic clk;
  logic rst;
  logic vtx_valid;
  logic vtx_stall;
  vtx_t vtx;
  logic res_valid;
  logic res_stall;
  res_t res;
  int   errors;
  int   pending;
  int   degen_seen;
  int   sent;
  int   stall_mode;

  triangle_normal_and_area_top u_dut (
    .clk(clk), .rst(rst), .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  tna_checker u_chk (
    .clk(clk), .rst(rst), .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .errors(errors), .pending(pending), .degen_seen(degen_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver stall pattern: mode changes now and then
  always @(posedge clk) begin
    if (rst) begin
      res_stall  <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 1) == 0);
        default: res_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Present one triangle and hold it until accepted
  task automatic send_triangle(vtx_t t);
    logic stalled;
    vtx       <= t;
    vtx_valid <= 1'b1;
    do begin
      @(negedge clk);
      stalled = vtx_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      vtx_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic vtx_t make_tri(int ax, int ay, int az,
                                    int bx, int by, int bz,
                                    int cx, int cy, int cz);
    vtx_t t;
    t = '{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
          16'(cx), 16'(cy), 16'(cz)};
    return t;
  endfunction

  // Random triangle: full range, small, collinear, repeated vertex, axis plane, extreme coordinates
  function automatic vtx_t random_tri();
    vtx_t t;
    int   k;
    int   dx;
    int   dy;
    int   dz;
    t = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
    k = $urandom_range(0, 9);
    if (k == 5) begin
      t.a_x = 16'($urandom_range(0, 20)); t.a_y = 16'($urandom_range(0, 20));
      t.a_z = 16'($urandom_range(0, 20)); t.b_x = 16'($urandom_range(0, 20));
      t.b_y = 16'($urandom_range(0, 20)); t.b_z = 16'($urandom_range(0, 20));
      t.c_x = 16'($urandom_range(0, 20)); t.c_y = 16'($urandom_range(0, 20));
      t.c_z = 16'($urandom_range(0, 20));
    end else if (k == 6) begin
      dx = $urandom_range(0, 200); dy = $urandom_range(0, 200); dz = $urandom_range(0, 200);
      t.a_x = 16'($urandom_range(0, 60000)); t.a_y = 16'($urandom_range(0, 60000));
      t.a_z = 16'($urandom_range(0, 60000));
      t.b_x = 16'(t.a_x + dx); t.b_y = 16'(t.a_y + dy); t.b_z = 16'(t.a_z + dz);
      t.c_x = 16'(t.a_x + 2 * dx); t.c_y = 16'(t.a_y + 2 * dy);
      t.c_z = 16'(t.a_z + 2 * dz);
    end else if (k == 7) begin
      t.c_x = t.a_x; t.c_y = t.a_y; t.c_z = t.a_z;
    end else if (k == 8) begin
      t.b_z = t.a_z; t.c_z = t.a_z;
    end else if (k == 9) begin
      t.a_x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      t.b_y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      t.c_z = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    return t;
  endfunction

  // Run limit
  initial begin
    #8000000;
    $display("[triangle_normal_and_area_top] ERROR");
    $finish;
  end

  initial begin
    int burst;
    int waited;
    rst       = 1'b1;
    vtx_valid = 1'b0;
    vtx       = '0;
    sent      = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: degenerate, unit axes both signs, extremes, collinear
    send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_triangle('1);
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    send_triangle(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
    send_triangle(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
    send_triangle(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_triangle(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
    send_triangle(make_tri(0, 0, 0, 65535, 0, 0, 0, 65535, 0));
    send_triangle(make_tri(65535, 65535, 65535, 0, 65535, 65535, 65535, 0, 65535));
    send_triangle(make_tri(0, 65535, 0, 65535, 0, 65535, 65535, 65535, 0));
    send_triangle(make_tri(65535, 0, 32768, 0, 65535, 0, 0, 0, 65535));
    send_triangle(make_tri(0, 0, 65535, 65535, 0, 0, 0, 65535, 0));
    send_triangle(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
    send_triangle(make_tri(5, 5, 5, 5, 5, 5, 9, 1, 7));
    send_triangle(make_tri(0, 0, 0, 1, 1, 1, 1, 0, 0));
    send_triangle(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 1));
    send_triangle(make_tri(65535, 65535, 65535, 0, 0, 0, 65535, 0, 0));

    // Random bursts with gaps; full drains after bursts that end between 600 and 639 sent
    while (sent < 1170) begin
      burst = $urandom_range(1, 30);
      repeat (burst) send_triangle(random_tri());
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
      if (sent >= 600 && sent < 640) begin
        vtx_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end
    vtx_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);

    $display("Sent %0d triangles (%0d degenerate results) under bursty input and output stalls",
             sent, degen_seen);
    if (errors == 0 && pending == 0) begin
      $display("[triangle_normal_and_area_top] OK");
    end else begin
      $display("[triangle_normal_and_area_top] ERROR");
    end
    $finish;
  end

endmodule
